// ----- hw/rtl/srms_pkg.sv -----
// Shared types, sizes and codes of the sparse row matrix store.
// Depends on nothing; the datapath, controller and top level take its names by scope.
`timescale 1ns / 1ps

package srms_pkg;

    // Store sizes.
    localparam int ROW_CAPACITY   = 1024;
    localparam int ENTRY_CAPACITY = 4096;

    // Address widths and counter widths (a counter can hold the capacity itself).
    localparam int ROW_AW = $clog2(ROW_CAPACITY);
    localparam int ROW_CW = $clog2(ROW_CAPACITY + 1);
    localparam int ENT_AW = $clog2(ENTRY_CAPACITY);
    localparam int ENT_CW = $clog2(ENTRY_CAPACITY + 1);

    // Field widths.
    localparam int OP_W   = 2;
    localparam int COL_W  = 16;
    localparam int ROW_W  = 16;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int SIZE_W = 17;

    // Stream word widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((COL_W + ROW_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VAL_W + SIZE_W + 7) / 8) * 8;

    // Entry memory word: column above value.
    localparam int ENT_DW = COL_W + VAL_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ = 2'd0;
    localparam logic [OP_W-1:0] OP_SET  = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD  = 2'd2;
    localparam logic [OP_W-1:0] OP_SUB  = 2'd3;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_NOSEQ = 2'd1;
    localparam logic [ST_W-1:0] ST_CAP   = 2'd2;

    // Source of the result value.
    localparam logic [1:0] RES_ZERO  = 2'd0;
    localparam logic [1:0] RES_EMPTY = 2'd1;
    localparam logic [1:0] RES_ENTRY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            load_item;
        logic            upd_cols;
        logic            res_load;
        logic [1:0]      res_src;
        logic [ST_W-1:0] res_status;
        logic            rs_rd_beg;
        logic            rs_rd_end;
        logic            latch_beg;
        logic            latch_end_mem;
        logic            latch_end_cnt;
        logic            scan_init;
        logic            scan_step;
        logic            hit_write;
        logic            fill_init;
        logic            fill_step;
        logic            append;
        logic            open_rows;
        logic            load_out;
    } srms_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic val_is_empty;
        logic row_in_range;
        logic row_over_cap;
        logic entries_full;
        logic next_in_range;
        logic is_last_row;
        logic last_col_gt;
        logic row_empty;
        logic hit;
        logic exhausted;
        logic fill_last;
        logic out_free;
    } srms_sts_t;

endpackage

// ----- hw/rtl/srms_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module srms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/srms_datapath.sv -----
// Datapath of the sparse row matrix store: item, counters, both memories,
// entry scan, saturating update and output register. Depends on srms_pkg and srms_ram.
`timescale 1ns / 1ps

module srms_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [srms_pkg::VAL_W-1:0]       cfg_data,
    input  logic [srms_pkg::OP_W-1:0]        s_tuser,
    input  logic [srms_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tready,
    input  srms_pkg::srms_cmd_t              cmd,
    output srms_pkg::srms_sts_t              sts,
    output logic                             m_tvalid,
    output logic [srms_pkg::ST_W-1:0]        m_tuser,
    output logic [srms_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int PAD_W = srms_pkg::M_TDATA_W - srms_pkg::VAL_W - srms_pkg::SIZE_W;

    // Item registers.
    logic [srms_pkg::OP_W-1:0]   op_reg;
    logic [srms_pkg::COL_W-1:0]  col_reg;
    logic [srms_pkg::ROW_W-1:0]  row_reg;
    logic [srms_pkg::VAL_W-1:0]  val_reg;
    logic [srms_pkg::VAL_W-1:0]  empty_reg;

    // Matrix bookkeeping.
    logic [srms_pkg::ROW_CW-1:0] rows_used_reg;
    logic [srms_pkg::ENT_CW-1:0] entries_used_reg;
    logic [srms_pkg::SIZE_W-1:0] column_count_reg;
    logic [srms_pkg::COL_W-1:0]  last_col_reg;

    // Row bounds and scan.
    logic [srms_pkg::ENT_CW-1:0] beg_reg;
    logic [srms_pkg::ENT_CW-1:0] end_reg;
    logic [srms_pkg::ENT_CW-1:0] idx_reg;
    logic [srms_pkg::ENT_AW-1:0] chk_idx_reg;
    logic                        chk_vld_reg;
    logic [srms_pkg::ROW_AW-1:0] fill_reg;

    // Result and output registers.
    logic [srms_pkg::VAL_W-1:0]  res_value_reg;
    logic [srms_pkg::ST_W-1:0]   res_status_reg;
    logic                        out_valid_reg;
    logic [srms_pkg::VAL_W-1:0]  out_value_reg;
    logic [srms_pkg::ST_W-1:0]   out_status_reg;
    logic [srms_pkg::SIZE_W-1:0] out_size_reg;

    // Memory ports.
    logic                        rs_wr_en;
    logic                        rs_rd_en;
    logic [srms_pkg::ROW_AW-1:0] rs_rd_addr;
    logic [srms_pkg::ENT_CW-1:0] rs_rdata;
    logic                        ent_wr_en;
    logic [srms_pkg::ENT_AW-1:0] ent_wr_addr;
    logic [srms_pkg::ENT_DW-1:0] ent_wr_data;
    logic                        ent_rd_en;
    logic [srms_pkg::ENT_DW-1:0] ent_rdata;

    // Derived values.
    logic [srms_pkg::SIZE_W-1:0] row_ext;
    logic [srms_pkg::SIZE_W-1:0] row_plus1;
    logic [srms_pkg::SIZE_W-1:0] rows_used_ext;
    logic [srms_pkg::SIZE_W-1:0] col_plus1;
    logic [srms_pkg::SIZE_W-1:0] size_now;
    logic                        scan_more;
    logic [srms_pkg::VAL_W:0]    cur_ext;
    logic [srms_pkg::VAL_W:0]    opd_ext;
    logic [srms_pkg::VAL_W:0]    sum;
    logic [srms_pkg::VAL_W-1:0]  sum_sat;
    logic [srms_pkg::VAL_W-1:0]  new_val;
    logic [srms_pkg::VAL_W-1:0]  res_value_next;

    assign row_ext       = {1'b0, row_reg};
    assign row_plus1     = row_ext + srms_pkg::SIZE_W'(1);
    assign rows_used_ext = srms_pkg::SIZE_W'(rows_used_reg);
    assign col_plus1     = {1'b0, col_reg} + srms_pkg::SIZE_W'(1);
    assign size_now      = (rows_used_ext > column_count_reg) ? rows_used_ext
                                                             : column_count_reg;
    assign scan_more     = (idx_reg < end_reg);

    // Saturating add or subtract of the stored value and the operand.
    assign cur_ext = {ent_rdata[srms_pkg::VAL_W-1], ent_rdata[srms_pkg::VAL_W-1:0]};
    assign opd_ext = {val_reg[srms_pkg::VAL_W-1], val_reg};
    assign sum     = (op_reg == srms_pkg::OP_SUB) ? (cur_ext - opd_ext) : (cur_ext + opd_ext);

    always_comb
    begin
        if (sum[srms_pkg::VAL_W] != sum[srms_pkg::VAL_W-1])
        begin
            sum_sat = sum[srms_pkg::VAL_W] ? {1'b1, {(srms_pkg::VAL_W-1){1'b0}}}
                                           : {1'b0, {(srms_pkg::VAL_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum[srms_pkg::VAL_W-1:0];
        end
    end

    always_comb
    begin
        case (op_reg)
            srms_pkg::OP_SET: new_val = val_reg;
            srms_pkg::OP_ADD: new_val = sum_sat;
            srms_pkg::OP_SUB: new_val = sum_sat;
            default:          new_val = val_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.res_src)
            srms_pkg::RES_ZERO:  res_value_next = '0;
            srms_pkg::RES_EMPTY: res_value_next = empty_reg;
            srms_pkg::RES_ENTRY: res_value_next = ent_rdata[srms_pkg::VAL_W-1:0];
            default:             res_value_next = '0;
        endcase
    end

    // Row start memory: written while opening rows, read for row bounds.
    assign rs_wr_en   = cmd.fill_step;
    assign rs_rd_en   = cmd.rs_rd_beg | cmd.rs_rd_end;
    assign rs_rd_addr = cmd.rs_rd_end ? row_plus1[srms_pkg::ROW_AW-1:0]
                                      : row_reg[srms_pkg::ROW_AW-1:0];

    srms_ram #(
        .WIDTH (srms_pkg::ENT_CW),
        .DEPTH (srms_pkg::ROW_CAPACITY)
    ) u_row_start (
        .clk     (clk),
        .wr_en   (rs_wr_en),
        .wr_addr (fill_reg),
        .wr_data (entries_used_reg),
        .rd_en   (rs_rd_en),
        .rd_addr (rs_rd_addr),
        .rd_data (rs_rdata)
    );

    // Entry memory: an update in place or an append at the end.
    assign ent_wr_en   = cmd.hit_write | cmd.append;
    assign ent_wr_addr = cmd.hit_write ? chk_idx_reg
                                       : entries_used_reg[srms_pkg::ENT_AW-1:0];
    assign ent_wr_data = cmd.hit_write ? {col_reg, new_val} : {col_reg, val_reg};
    assign ent_rd_en   = cmd.scan_step & scan_more;

    srms_ram #(
        .WIDTH (srms_pkg::ENT_DW),
        .DEPTH (srms_pkg::ENTRY_CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (ent_rd_en),
        .rd_addr (idx_reg[srms_pkg::ENT_AW-1:0]),
        .rd_data (ent_rdata)
    );

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg        <= '0;
            rows_used_reg    <= '0;
            entries_used_reg <= '0;
            column_count_reg <= '0;
            chk_vld_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                empty_reg <= cfg_data;
            end
            if (cmd.upd_cols && (col_plus1 > column_count_reg))
            begin
                column_count_reg <= col_plus1;
            end
            if (cmd.open_rows)
            begin
                rows_used_reg <= row_plus1[srms_pkg::ROW_CW-1:0];
            end
            if (cmd.append)
            begin
                entries_used_reg <= entries_used_reg + srms_pkg::ENT_CW'(1);
            end
            if (cmd.scan_init)
            begin
                chk_vld_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                chk_vld_reg <= scan_more;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg  <= s_tuser;
            col_reg <= s_tdata[srms_pkg::COL_W-1:0];
            row_reg <= s_tdata[srms_pkg::COL_W +: srms_pkg::ROW_W];
            val_reg <= s_tdata[srms_pkg::COL_W + srms_pkg::ROW_W +: srms_pkg::VAL_W];
        end
        if (cmd.append)
        begin
            last_col_reg <= col_reg;
        end
        if (cmd.latch_beg)
        begin
            beg_reg <= rs_rdata;
        end
        if (cmd.latch_end_mem)
        begin
            end_reg <= rs_rdata;
        end
        else if (cmd.latch_end_cnt)
        begin
            end_reg <= entries_used_reg;
        end
        if (cmd.scan_init)
        begin
            idx_reg <= beg_reg;
        end
        else if (cmd.scan_step && scan_more)
        begin
            idx_reg     <= idx_reg + srms_pkg::ENT_CW'(1);
            chk_idx_reg <= idx_reg[srms_pkg::ENT_AW-1:0];
        end
        if (cmd.fill_init)
        begin
            fill_reg <= rows_used_reg[srms_pkg::ROW_AW-1:0];
        end
        else if (cmd.fill_step)
        begin
            fill_reg <= fill_reg + srms_pkg::ROW_AW'(1);
        end
        if (cmd.res_load)
        begin
            res_value_reg  <= res_value_next;
            res_status_reg <= cmd.res_status;
        end
        if (cmd.load_out)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
            out_size_reg   <= size_now;
        end
    end

    // Status to the controller.
    assign sts.is_read       = (op_reg == srms_pkg::OP_READ);
    assign sts.val_is_empty  = (val_reg == empty_reg);
    assign sts.row_in_range  = (row_ext < rows_used_ext);
    assign sts.row_over_cap  = (row_ext >= srms_pkg::SIZE_W'(srms_pkg::ROW_CAPACITY));
    assign sts.entries_full  = (entries_used_reg == srms_pkg::ENT_CW'(srms_pkg::ENTRY_CAPACITY));
    assign sts.next_in_range = (row_plus1 < rows_used_ext);
    assign sts.is_last_row   = (row_plus1 == rows_used_ext);
    assign sts.last_col_gt   = (last_col_reg > col_reg);
    assign sts.row_empty     = (beg_reg == end_reg);
    assign sts.hit           = chk_vld_reg
                               && (ent_rdata[srms_pkg::ENT_DW-1:srms_pkg::VAL_W] == col_reg);
    assign sts.exhausted     = !chk_vld_reg && !scan_more;
    assign sts.fill_last     = (fill_reg == row_reg[srms_pkg::ROW_AW-1:0]);
    assign sts.out_free      = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_size_reg, out_value_reg};

endmodule

// ----- hw/rtl/srms_ctrl.sv -----
// Controller of the sparse row matrix store: walks each item through
// decision, row bounds, entry scan or row opening, and hand-over. Depends on srms_pkg.
`timescale 1ns / 1ps

module srms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  srms_pkg::srms_sts_t sts,
    output srms_pkg::srms_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_RBEG   = 3'd2;
    localparam logic [2:0] S_REND   = 3'd3;
    localparam logic [2:0] S_SCAN0  = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_FILL   = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.is_read)
                begin
                    if (!sts.row_in_range)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_src  = srms_pkg::RES_EMPTY;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        cmd.rs_rd_beg = 1'b1;
                        state_next    = S_RBEG;
                    end
                end
                else
                begin
                    cmd.upd_cols = 1'b1;
                    if (sts.val_is_empty)
                    begin
                        cmd.res_load = 1'b1;
                        state_next   = S_FINISH;
                    end
                    else if (!sts.row_in_range)
                    begin
                        if (sts.row_over_cap || sts.entries_full)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = srms_pkg::ST_CAP;
                            state_next     = S_FINISH;
                        end
                        else
                        begin
                            cmd.fill_init = 1'b1;
                            state_next    = S_FILL;
                        end
                    end
                    else
                    begin
                        cmd.rs_rd_beg = 1'b1;
                        state_next    = S_RBEG;
                    end
                end
            end
            S_RBEG:
            begin
                cmd.latch_beg = 1'b1;
                if (sts.next_in_range)
                begin
                    cmd.rs_rd_end = 1'b1;
                    state_next    = S_REND;
                end
                else
                begin
                    cmd.latch_end_cnt = 1'b1;
                    state_next        = S_SCAN0;
                end
            end
            S_REND:
            begin
                cmd.latch_end_mem = 1'b1;
                state_next        = S_SCAN0;
            end
            S_SCAN0:
            begin
                if (sts.row_empty)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_src  = sts.is_read ? srms_pkg::RES_EMPTY : srms_pkg::RES_ZERO;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.hit)
                begin
                    cmd.res_load = 1'b1;
                    if (sts.is_read)
                    begin
                        cmd.res_src = srms_pkg::RES_ENTRY;
                    end
                    else
                    begin
                        cmd.hit_write = 1'b1;
                    end
                    state_next = S_FINISH;
                end
                else if (sts.exhausted)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_FINISH;
                    if (sts.is_read)
                    begin
                        cmd.res_src = srms_pkg::RES_EMPTY;
                    end
                    else if (!sts.is_last_row || sts.last_col_gt)
                    begin
                        cmd.res_status = srms_pkg::ST_NOSEQ;
                    end
                    else if (sts.entries_full)
                    begin
                        cmd.res_status = srms_pkg::ST_CAP;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                    end
                end
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    cmd.append    = 1'b1;
                    cmd.open_rows = 1'b1;
                    cmd.res_load  = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/sparse_row_matrix_store_unit.sv -----
// Top level of the sparse row matrix store: controller, datapath and checks.
// Depends on srms_pkg, srms_ctrl, srms_datapath (and srms_ram below it).
`timescale 1ns / 1ps

// Channel   Direction  Word
// s_*       in         tuser = op; tdata = col, row, value (low bits first)
// m_*       out        tuser = status; tdata = read_value, matrix_size
// cfg_*     in         data = empty value (Q16.16)
//
// Each item takes its own pass through the controller: acceptance, a decision, then
// a fetch of the row bounds from the row start memory and a scan of that row through
// the entry memory's single read port, one entry a cycle, up to the match or the end of
// the row; for the last row in use the end bound comes from the entry counter instead.
// A read beyond the rows in use, or a write of the empty value, skips the bounds and
// the scan. Opening a row writes one row start a cycle for itself and every skipped row
// before it.
// Reset clears the counters and the empty value; the memories need no clearing, since
// only entries below the counters are ever read. A stalled output holds the finished
// word while the next item is already accepted and worked on.

module sparse_row_matrix_store_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [srms_pkg::VAL_W-1:0]          cfg_data,   // empty value
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [srms_pkg::OP_W-1:0]           s_tuser,    // op
    input  logic [srms_pkg::S_TDATA_W-1:0]      s_tdata,    // col, row, value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [srms_pkg::ST_W-1:0]           m_tuser,    // status
    output logic [srms_pkg::M_TDATA_W-1:0]      m_tdata     // read_value, matrix_size, zeros
);

    srms_pkg::srms_cmd_t cmd;
    srms_pkg::srms_sts_t sts;

    // The empty value is to be written only while the block is quiet; the block itself does not enforce this.
    assign cfg_ready = 1'b1;

    srms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    srms_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    // Only one item is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // A write that did not succeed always reports a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != srms_pkg::ST_OK) |-> (m_tdata[srms_pkg::VAL_W-1:0] == '0))
        else $error("failed write reports a non-zero value");

    // No entry is appended to a full store.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !sts.entries_full)
        else $error("entry appended beyond capacity");

    // The output word is only replaced once the previous one has been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("output word overwritten before it was taken");
`endif

endmodule
